FILE: rtl/ranked_loop_candidate_select_defines.svh
// assertion macros for the ranked loop candidate select block
// used by rtl modules that carry concurrent checks; needs i_clk and i_rst_n in scope
`ifndef RANKED_LOOP_CANDIDATE_SELECT_DEFINES_SVH
`define RANKED_LOOP_CANDIDATE_SELECT_DEFINES_SVH
`ifndef SYNTHESIS
`define RLCS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("rlcs assertion failed");
`define RLCS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rlcs implication failed");
`else
`define RLCS_ASSERT(lbl, prop)
`define RLCS_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

FILE: rtl/rlcs_pkg.sv
// shared types and constants for the ranked loop candidate select block
// no dependencies
package rlcs_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int COORD_BITS_DEF  = 24;
    localparam int RESULT_LIMIT    = 32;
    localparam int ID_BITS         = 32;
    localparam int SQ_BITS         = 50;
    localparam int LIM_BITS        = 46;
    localparam int OUT_DW          = 88;
    localparam int CFG_DW          = 23;
    localparam int CFG_AW          = 2;

    localparam logic [SQ_BITS-1:0] SQ_MAX = {SQ_BITS{1'b1}};

    localparam logic [CFG_AW-1:0] CFG_MAX_ENTRIES = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_MIN_SEP     = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_MAX_DIST    = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INSERT,
        S_QSTART,
        S_READ,
        S_DIFF,
        S_MULX,
        S_MULY,
        S_MULZ,
        S_RANK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic idle;
        logic load;
        logic ins;
        logic clr;
        logic rd;
        logic diff;
        logic mulx;
        logic muly;
        logic mulz;
        logic rank;
        logic emit;
        logic pop;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_last;
    } t_sts;

endpackage

FILE: rtl/rlcs_ctrl.sv
// controller state machine for the ranked loop candidate select block
// depends on rlcs_pkg; drives commands into rlcs_dpath
module rlcs_ctrl import rlcs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_func,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.idle = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = i_in_func ? S_QSTART : S_INSERT;
                end
            end
            S_INSERT: begin
                o_cmd.ins = 1'b1;
                n_state = S_IDLE;
            end
            S_QSTART: begin
                o_cmd.clr = 1'b1;
                n_state = S_READ;
            end
            S_READ: begin
                if (i_sts.scan_done) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state = S_MULX;
            end
            S_MULX: begin
                o_cmd.mulx = 1'b1;
                n_state = S_MULY;
            end
            S_MULY: begin
                o_cmd.muly = 1'b1;
                n_state = S_MULZ;
            end
            S_MULZ: begin
                o_cmd.mulz = 1'b1;
                n_state = S_RANK;
            end
            S_RANK: begin
                o_cmd.rank = 1'b1;
                n_state = S_READ;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_out_ready) begin
                    o_cmd.pop = 1'b1;
                    if (i_sts.out_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/rlcs_dpath.sv
// datapath: config registers, entry table memory, distance unit and ranked list
// depends on rlcs_pkg and ranked_loop_candidate_select_defines.svh; driven by rlcs_ctrl
`include "ranked_loop_candidate_select_defines.svh"
module rlcs_dpath import rlcs_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic                    i_cfg_we,
    input  logic [CFG_AW-1:0]       i_cfg_index,
    input  logic [CFG_DW-1:0]       i_cfg_data,
    input  logic [ID_BITS-1:0]      i_item_id,
    input  logic [COORD_BITS-1:0]   i_pos_x,
    input  logic [COORD_BITS-1:0]   i_pos_y,
    input  logic [COORD_BITS-1:0]   i_pos_z,
    output logic                    o_found,
    output logic [ID_BITS-1:0]      o_cand_id,
    output logic [SQ_BITS-1:0]      o_sq_distance,
    output logic                    o_last
);

    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int SW   = AW + 1;
    localparam int EW   = ID_BITS + 3 * COORD_BITS;
    localparam int SQW  = 2 * COORD_BITS + 2;
    localparam int RL   = RESULT_LIMIT;
    localparam int NW   = $clog2(RL + 1);
    localparam int CMPW = (SQW > LIM_BITS) ? SQW : LIM_BITS;
    localparam int SXW  = (SQW > SQ_BITS) ? SQW : SQ_BITS;

    // config
    logic [5:0]          r_max_entries;
    logic [15:0]         r_min_sep;
    logic [CFG_DW-1:0]   r_max_dist;
    logic [LIM_BITS-1:0] r_lim;
    logic [LIM_BITS-1:0] w_lim;

    assign w_lim = LIM_BITS'(i_cfg_data) * LIM_BITS'(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= 6'd32;
            r_min_sep     <= '0;
            r_max_dist    <= '0;
            r_lim         <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_ENTRIES: r_max_entries <= i_cfg_data[5:0];
                CFG_MIN_SEP:     r_min_sep <= i_cfg_data[15:0];
                CFG_MAX_DIST: begin
                    r_max_dist <= i_cfg_data;
                    r_lim      <= w_lim;
                end
                default: ;
            endcase
        end
    end

    // captured item
    logic [ID_BITS-1:0]    r_qid;
    logic [COORD_BITS-1:0] r_qx, r_qy, r_qz;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_qid <= i_item_id;
            r_qx  <= i_pos_x;
            r_qy  <= i_pos_y;
            r_qz  <= i_pos_z;
        end
    end

    // circular table bookkeeping
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_oldest;

    function automatic logic [AW-1:0] wrap_slot(input logic [SW-1:0] v);
        if (v >= SW'(TABLE_DEPTH)) begin
            return AW'(v - SW'(TABLE_DEPTH));
        end
        return AW'(v);
    endfunction

    logic          w_full;
    logic [AW-1:0] w_old0;
    logic [CW-1:0] w_cnt0;
    logic [CW-1:0] w_cnt1;
    logic [AW-1:0] w_wslot;
    logic [CW-1:0] w_cap;
    logic          w_over;
    logic [CW-1:0] w_drop;

    always_comb begin
        w_full  = (r_count == CW'(TABLE_DEPTH));
        w_old0  = w_full ? wrap_slot(SW'(r_oldest) + SW'(1)) : r_oldest;
        w_cnt0  = w_full ? CW'(TABLE_DEPTH - 1) : r_count;
        w_wslot = wrap_slot(SW'(w_old0) + SW'(w_cnt0));
        w_cnt1  = w_cnt0 + CW'(1);
        w_cap   = ({1'b0, r_max_entries} > 7'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                            : CW'(r_max_entries);
        w_over  = (w_cnt1 > w_cap);
        w_drop  = w_cnt1 - w_cap;
    end

    // scan position
    logic [CW-1:0] r_k;
    logic [AW-1:0] r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_oldest <= '0;
        end else if (i_cmd.ins) begin
            r_count  <= w_over ? w_cap : w_cnt1;
            r_oldest <= w_over ? wrap_slot(SW'(w_old0) + SW'(w_drop)) : w_old0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_k    <= '0;
            r_slot <= r_oldest;
        end else if (i_cmd.rank) begin
            r_k    <= r_k + CW'(1);
            r_slot <= (r_slot == AW'(TABLE_DEPTH - 1)) ? '0 : r_slot + AW'(1);
        end
    end

    assign o_sts.scan_done = (r_k == r_count);

    // entry memory
    logic [EW-1:0] r_mem [TABLE_DEPTH];
    logic [EW-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            r_mem[w_wslot] <= {r_qz, r_qy, r_qx, r_qid};
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[r_slot];
        end
    end

    // distance unit with one shared multiplier
    logic [ID_BITS-1:0]      w_eid;
    logic [COORD_BITS-1:0]   w_ex, w_ey, w_ez;
    logic [ID_BITS-1:0]      w_thr;
    logic signed [COORD_BITS:0] r_dx, r_dy, r_dz;
    logic signed [COORD_BITS:0] w_mop;
    logic signed [2*COORD_BITS+1:0] w_prod;
    logic                    r_elig;
    logic [SQW-1:0]          r_acc;

    assign w_eid = r_rd[ID_BITS-1:0];
    assign w_ex  = r_rd[ID_BITS +: COORD_BITS];
    assign w_ey  = r_rd[ID_BITS + COORD_BITS +: COORD_BITS];
    assign w_ez  = r_rd[ID_BITS + 2 * COORD_BITS +: COORD_BITS];
    assign w_thr = w_eid + ID_BITS'(r_min_sep);

    always_comb begin
        if (i_cmd.mulx) begin
            w_mop = r_dx;
        end else if (i_cmd.muly) begin
            w_mop = r_dy;
        end else begin
            w_mop = r_dz;
        end
    end

    assign w_prod = w_mop * w_mop;

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            r_dx   <= $signed({r_qx[COORD_BITS-1], r_qx}) - $signed({w_ex[COORD_BITS-1], w_ex});
            r_dy   <= $signed({r_qy[COORD_BITS-1], r_qy}) - $signed({w_ey[COORD_BITS-1], w_ey});
            r_dz   <= $signed({r_qz[COORD_BITS-1], r_qz}) - $signed({w_ez[COORD_BITS-1], w_ez});
            r_elig <= (r_qid > w_thr);
        end
        if (i_cmd.mulx) begin
            r_acc <= SQW'(unsigned'(w_prod));
        end else if (i_cmd.muly || i_cmd.mulz) begin
            r_acc <= r_acc + SQW'(unsigned'(w_prod));
        end
    end

    // ranked list, nearest first, equal keys keep arrival order
    logic [SQW-1:0]     r_ckey [RL];
    logic [ID_BITS-1:0] r_cid  [RL];
    logic [NW-1:0]      r_cnt;
    logic [SQW-1:0]     n_ckey [RL];
    logic [ID_BITS-1:0] n_cid  [RL];
    logic [NW-1:0]      n_cnt;
    logic [RL-1:0]      w_ins;
    logic [RL-1:0]      w_ins_prev;
    logic               w_keep;

    assign w_keep = r_elig &&
                    ((r_max_dist == '0) || (CMPW'(r_acc) <= CMPW'(r_lim)));

    always_comb begin
        for (int j = 0; j < RL; j++) begin
            w_ins[j] = (NW'(j) >= r_cnt) || (r_ckey[j] > r_acc);
        end
        w_ins_prev[0] = 1'b0;
        for (int j = 1; j < RL; j++) begin
            w_ins_prev[j] = w_ins[j-1];
        end
        n_ckey = r_ckey;
        n_cid  = r_cid;
        n_cnt  = r_cnt;
        if (i_cmd.clr) begin
            n_cnt = '0;
        end else if (i_cmd.rank && w_keep) begin
            for (int j = 0; j < RL; j++) begin
                if (w_ins[j] && w_ins_prev[j]) begin
                    n_ckey[j] = r_ckey[(j > 0) ? j - 1 : 0];
                    n_cid[j]  = r_cid[(j > 0) ? j - 1 : 0];
                end else if (w_ins[j]) begin
                    n_ckey[j] = r_acc;
                    n_cid[j]  = w_eid;
                end
            end
            if (r_cnt < NW'(RL)) begin
                n_cnt = r_cnt + NW'(1);
            end
        end else if (i_cmd.pop) begin
            for (int j = 0; j < RL - 1; j++) begin
                n_ckey[j] = r_ckey[j+1];
                n_cid[j]  = r_cid[j+1];
            end
            if (r_cnt != '0) begin
                n_cnt = r_cnt - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ckey <= n_ckey;
        r_cid  <= n_cid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // result head
    logic [SXW-1:0]     w_key_ext;
    logic [SQ_BITS-1:0] w_sq_sat;

    assign w_key_ext = SXW'(r_ckey[0]);
    assign w_sq_sat  = (w_key_ext > SXW'(SQ_MAX)) ? SQ_MAX : SQ_BITS'(w_key_ext);

    assign o_found         = (r_cnt != '0);
    assign o_cand_id       = o_found ? r_cid[0] : '0;
    assign o_sq_distance   = o_found ? w_sq_sat : '0;
    assign o_last          = (r_cnt <= NW'(1));
    assign o_sts.out_last  = o_last;

    `RLCS_ASSERT(a_count_in_range, r_count <= CW'(TABLE_DEPTH))
    `RLCS_ASSERT_IMPL(a_list_sorted, r_cnt >= NW'(2), r_ckey[0] <= r_ckey[1])
    `RLCS_ASSERT(a_pop_shrinks, (i_cmd.pop && r_cnt != '0) |=> r_cnt == $past(r_cnt) - NW'(1))

endmodule

FILE: rtl/ranked_loop_candidate_select.sv
// Ranked loop candidate select. Keeps a FIFO table of up to TABLE_DEPTH map entries
// (id and x/y/z position) and answers queries with the eligible entries sorted nearest
// first by squared distance, ties oldest first, at most 32 results per query. func 0
// inserts (no result), func 1 queries: for each stored entry the scan sequencer does
// one table memory read, forms the axis differences, squares the three axes in turn on
// one shared multiplier and ranks the entry; the ranked results follow the scan. One
// item is worked on at a time. Config writes take effect at once.
// depends on rlcs_pkg, rlcs_ctrl and rlcs_dpath
module ranked_loop_candidate_select import rlcs_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // item_id, pos_x, pos_y, pos_z, zero pad
    input  logic [((ID_BITS + 3 * COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // func
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // cand_id, sq_distance, zero pad
    output logic [OUT_DW-1:0]     m_axis_tdata,
    // found
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_AW-1:0]     i_cfg_index,
    input  logic [CFG_DW-1:0]     i_cfg_data
);

    t_cmd               w_cmd;
    t_sts               w_sts;
    logic [ID_BITS-1:0] w_cand_id;
    logic [SQ_BITS-1:0] w_sq;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = w_cmd.idle;
    assign m_axis_tvalid = w_cmd.emit;
    assign m_axis_tdata  = {(OUT_DW - ID_BITS - SQ_BITS)'(0), w_sq, w_cand_id};

    rlcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_func   (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rlcs_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_item_id     (s_axis_tdata[ID_BITS-1:0]),
        .i_pos_x       (s_axis_tdata[ID_BITS +: COORD_BITS]),
        .i_pos_y       (s_axis_tdata[ID_BITS + COORD_BITS +: COORD_BITS]),
        .i_pos_z       (s_axis_tdata[ID_BITS + 2 * COORD_BITS +: COORD_BITS]),
        .o_found       (m_axis_tuser),
        .o_cand_id     (w_cand_id),
        .o_sq_distance (w_sq),
        .o_last        (m_axis_tlast)
    );

endmodule

FILE: bench/ranked_loop_candidate_select_tb.sv
// testbench for ranked_loop_candidate_select: random and directed inserts and queries
// against a behavioral candidate ranker, with random stalls on both stream sides
// depends on rlcs_pkg and ranked_loop_candidate_select
module ranked_loop_candidate_select_tb import rlcs_pkg::*; ();

    localparam int DEPTH = 32;
    localparam int IN_W = ((ID_BITS + 3 * 24 + 7) / 8) * 8;
    localparam int WATCH_LIMIT = 20000;
    localparam int ANS_DEPTH = 1024;

    typedef struct packed {
        logic        found;
        logic [31:0] cand_id;
        logic [49:0] sq;
        logic        last;
    } t_answer;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_DW-1:0] m_axis_tdata;
    logic              m_axis_tuser;
    logic              m_axis_tlast;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CFG_AW-1:0] i_cfg_index;
    logic [CFG_DW-1:0] i_cfg_data;

    ranked_loop_candidate_select dut (.*);

    // predictor state
    logic [5:0]         cap_reg;
    logic [15:0]        sep_reg;
    logic [22:0]        dist_reg;
    logic [31:0]        tab_id [DEPTH];
    logic signed [23:0] tab_x [DEPTH];
    logic signed [23:0] tab_y [DEPTH];
    logic signed [23:0] tab_z [DEPTH];
    int                 live_count;
    int                 head_slot;
    t_answer            ans_mem [ANS_DEPTH];
    int                 ans_wr;
    int                 ans_rd;
    int                 error_count;
    int                 idle_cycles;
    bit                 rx_stall_on;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic void ans_put(t_answer a);
        ans_mem[ans_wr % ANS_DEPTH] = a;
        ans_wr++;
    endfunction

    function automatic logic [49:0] axis_sq(logic signed [23:0] a, logic signed [23:0] b);
        logic signed [25:0] d;
        d = 26'(a) - 26'(b);
        return 50'(d * d);
    endfunction

    function automatic void rank_query(logic [31:0] qid, logic signed [23:0] qx,
                                       logic signed [23:0] qy, logic signed [23:0] qz);
        logic [31:0] ids [DEPTH];
        logic [49:0] dsq [DEPTH];
        logic [49:0] sq;
        logic [31:0] thr;
        logic [49:0] lim;
        t_answer     a;
        int          n;
        int          j;
        int          s;
        n = 0;
        lim = 50'(dist_reg) * 50'(dist_reg);
        for (int k = 0; k < live_count; k++) begin
            s = (head_slot + k) % DEPTH;
            thr = tab_id[s] + 32'(sep_reg);
            if (qid <= thr) continue;
            sq = axis_sq(qx, tab_x[s]) + axis_sq(qy, tab_y[s]) + axis_sq(qz, tab_z[s]);
            if (dist_reg != 0 && sq > lim) continue;
            j = n;
            while (j > 0 && dsq[j-1] > sq) begin
                dsq[j] = dsq[j-1];
                ids[j] = ids[j-1];
                j--;
            end
            dsq[j] = sq;
            ids[j] = tab_id[s];
            n++;
        end
        if (n == 0) begin
            a = '{found: 1'b0, cand_id: '0, sq: '0, last: 1'b1};
            ans_put(a);
        end
        for (int k = 0; k < n; k++) begin
            a = '{found: 1'b1, cand_id: ids[k], sq: dsq[k], last: k == n - 1};
            ans_put(a);
        end
    endfunction

    function automatic void store_entry(logic [31:0] id, logic signed [23:0] x,
                                        logic signed [23:0] y, logic signed [23:0] z);
        int cap;
        int slot;
        cap = cap_reg > DEPTH ? DEPTH : cap_reg;
        if (live_count >= DEPTH) begin
            head_slot = (head_slot + 1) % DEPTH;
            live_count--;
        end
        slot = (head_slot + live_count) % DEPTH;
        tab_id[slot] = id;
        tab_x[slot] = x;
        tab_y[slot] = y;
        tab_z[slot] = z;
        live_count++;
        while (live_count > cap) begin
            head_slot = (head_slot + 1) % DEPTH;
            live_count--;
        end
    endfunction

    // valid stays high after a transaction until the next gap or drain
    task automatic send_item(bit qry, logic [31:0] id, logic signed [23:0] x,
                             logic signed [23:0] y, logic signed [23:0] z);
        int g;
        g = gap_len();
        if (g != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= qry;
        s_axis_tdata  <= IN_W'({z, y, x, id});
        do @(posedge i_clk); while (!s_axis_tready);
        if (qry) rank_query(id, x, y, z);
        else store_entry(id, x, y, z);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (ans_wr != ans_rd) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MAX_ENTRIES: cap_reg = val[5:0];
            CFG_MIN_SEP:     sep_reg = val[15:0];
            CFG_MAX_DIST:    dist_reg = val;
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("error: %s got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    function automatic logic signed [23:0] rnd_coord(int spread);
        if (spread == 0) return 24'($urandom);
        return 24'($signed($urandom_range(2 * spread)) - spread);
    endfunction

    task automatic test_directed();
        send_item(1, 32'd5, 0, 0, 0);
        send_item(0, 32'd0, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
        send_item(0, 32'hffffffff, -24'sh800000, -24'sh800000, -24'sh800000);
        send_item(0, 32'd10, 24'sd3, 24'sd4, 0);
        send_item(0, 32'd11, -24'sd3, -24'sd4, 0);
        send_item(1, 32'hffffffff, 0, 0, 0);
        send_item(1, 32'd0, 0, 0, 0);
        send_item(1, 32'd11, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
        send_item(1, 32'd1, -24'sh800000, -24'sh800000, -24'sh800000);
        write_reg(CFG_MIN_SEP, 23'hffff);
        send_item(0, 32'hfffffff0, 1, 1, 1);
        send_item(1, 32'h00000005, 1, 1, 1);
        send_item(1, 32'd12, 0, 0, 0);
        write_reg(CFG_MIN_SEP, 0);
        write_reg(CFG_MAX_DIST, 23'd5);
        send_item(1, 32'd12, 0, 0, 0);
        write_reg(CFG_MAX_DIST, 23'h7fffff);
        send_item(1, 32'hffffffff, 0, 0, 0);
        write_reg(CFG_MAX_DIST, 0);
        write_reg(CFG_MAX_ENTRIES, 23'd2);
        send_item(1, 32'd12, 0, 0, 0);
        send_item(0, 32'd20, 0, 0, 0);
        send_item(1, 32'd30, 0, 0, 0);
        write_reg(CFG_MAX_ENTRIES, 0);
        send_item(0, 32'd21, 0, 0, 0);
        send_item(1, 32'd30, 0, 0, 0);
    endtask

    task automatic test_random_phase(int items, int capv, int sepv, int distv, int spread);
        logic [31:0] next_id;
        write_reg(CFG_MAX_ENTRIES, 23'(capv));
        write_reg(CFG_MIN_SEP, 23'(sepv));
        write_reg(CFG_MAX_DIST, 23'(distv));
        next_id = $urandom_range(1000);
        for (int i = 0; i < items; i++) begin
            next_id += $urandom_range(4);
            if ($urandom_range(9) < 6)
                send_item(0, next_id, rnd_coord(spread), rnd_coord(spread), rnd_coord(spread));
            else
                send_item(1, ($urandom_range(9) == 0) ? 32'($urandom) : next_id,
                          rnd_coord(spread), rnd_coord(spread), rnd_coord(spread));
            if (i == items / 2) drain();
        end
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        t_answer got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{found: m_axis_tuser, cand_id: m_axis_tdata[31:0],
                        sq: m_axis_tdata[81:32], last: m_axis_tlast};
                if (ans_wr == ans_rd) begin
                    report_mismatch("unexpected result", 64'(got.cand_id), 0);
                end else begin
                    want = ans_mem[ans_rd % ANS_DEPTH];
                    ans_rd++;
                    if (got.found !== want.found)
                        report_mismatch("found", 64'(got.found), 64'(want.found));
                    if (got.cand_id !== want.cand_id)
                        report_mismatch("cand_id", 64'(got.cand_id), 64'(want.cand_id));
                    if (got.sq !== want.sq)
                        report_mismatch("sq_distance", 64'(got.sq), 64'(want.sq));
                    if (got.last !== want.last)
                        report_mismatch("last", 64'(got.last), 64'(want.last));
                end
            end
            if (!rx_stall_on && $urandom_range(199) == 0) rx_stall_on = 1'b1;
            else if (rx_stall_on && $urandom_range(19) == 0) rx_stall_on = 1'b0;
            m_axis_tready <= rx_stall_on ? 1'b0 : ($urandom_range(9) < 6);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("ranked_loop_candidate_select: mismatch");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        cap_reg = 6'd32;
        sep_reg = '0;
        dist_reg = '0;
        live_count = 0;
        head_slot = 0;
        ans_wr = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phase(100, 32, 0, 0, 0);
        test_random_phase(80, 8, 3, 3000, 2000);
        test_random_phase(80, 63, 65535, 8388607, 0);
        test_random_phase(80, 1, 0, 1, 2);
        test_random_phase(60, 5, 2, 0, 3);
        drain();
        repeat (300) @(posedge i_clk);
        if (error_count == 0 && ans_wr == ans_rd) begin
            $display("ranked_loop_candidate_select: match");
        end else begin
            $display("ranked_loop_candidate_select: mismatch");
        end
        $finish;
    end
endmodule
